/* rtl/pdh_pkg.sv */
// ============================================================================
// pdh_pkg - shared types and constants for the dinucleotide histogram
// Base codes, class numbering, mode code and the result beat type.
// ============================================================================
`default_nettype none

package pdh_pkg;

    // Input mode codes
    localparam logic MODE_FEED  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Class numbering: 16 regular pairs plus the NN class
    localparam int unsigned NUM_CLASSES  = 17;
    localparam logic [4:0]  NN_CLASS     = 5'd16;
    localparam logic [2:0]  INVALID_CODE = 3'd4;

    // Fixed widths of the interface fields
    localparam int unsigned OUT_W       = 32;
    localparam int unsigned RLEN_W      = 9;
    localparam logic [8:0]  RLEN_RESET  = 9'd167;

    // Output queue depth
    localparam int unsigned OQ_DEPTH = 3;

    typedef struct packed {
        logic [OUT_W-1:0] position_count;
        logic [OUT_W-1:0] class_total;
    } t_result;

    // Map an ASCII base to 0..3, anything else to the invalid code
    function automatic logic [2:0] base_code(input logic [7:0] ch);
        logic [2:0] code;
        unique case (ch)
            8'h41, 8'h61: code = 3'd0;   // A a
            8'h43, 8'h63: code = 3'd1;   // C c
            8'h47, 8'h67: code = 3'd2;   // G g
            8'h54, 8'h74: code = 3'd3;   // T t
            default:      code = INVALID_CODE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

/* rtl/positional_dinucleotide_histogram_unit.sv */
// ============================================================================
// positional_dinucleotide_histogram_unit - per-position dinucleotide counter
// Counts adjacent base pairs of reads of the configured length by start
// position and class, keeps per-class totals, and answers read-out beats.
// ============================================================================
// Throughput: one input beat per cycle unless stalled, feed and read-out beats
//   alike; each beat does one read-modify-write (or read) of the counter RAMs.
// Read-out path: a read-out beat's RAM read is registered, then the
//   write-back/result stage pushes its result into a 3-entry output queue.
// Reset: a clearing pass writes zero through the counter RAMs, one entry per
//   cycle, covering all MAX_READ_LEN*17 entries; input is stalled meanwhile.
`default_nettype none

module positional_dinucleotide_histogram_unit #(
    parameter int unsigned MAX_READ_LEN = 256,
    parameter int unsigned COUNT_BITS   = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Configuration write channel
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [8:0]                 i_cfg_data,
    // Input channel
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic                       i_mode,
    input  wire logic [7:0]                 i_base,
    input  wire logic [8:0]                 i_read_len,
    input  wire logic                       i_last_base,
    input  wire logic [7:0]                 i_query_position,
    input  wire logic [4:0]                 i_query_class,
    // Output channel
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [pdh_pkg::OUT_W-1:0]       o_position_count,
    output logic [pdh_pkg::OUT_W-1:0]       o_class_total
);

    import pdh_pkg::*;

    localparam int unsigned DEPTH  = MAX_READ_LEN * NUM_CLASSES;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned POS_W  = (MAX_READ_LEN > 1) ? $clog2(MAX_READ_LEN) : 1;
    localparam int unsigned CMP_W  = (POS_W > RLEN_W) ? POS_W : RLEN_W;
    localparam logic [POS_W-1:0]      POS_LAST  = POS_W'(MAX_READ_LEN - 1);
    localparam logic [ADDR_W-1:0]     CLR_LAST  = ADDR_W'(DEPTH - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [RLEN_W-1:0]     r_read_length;
    logic [POS_W-1:0]      r_base_pos,   n_base_pos;
    logic [2:0]            r_prev_code,  n_prev_code;
    logic                  r_clr_active;
    logic [ADDR_W-1:0]     r_clr_addr;

    // Stage 1 (RAM data returns, write back, form result)
    logic                  r_s1_valid;
    logic                  r_s1_upd;
    logic                  r_s1_tot_upd;
    logic                  r_s1_query;
    logic                  r_s1_qcnt;
    logic                  r_s1_qtot;
    logic [ADDR_W-1:0]     r_s1_paddr;
    logic [3:0]            r_s1_taddr;

    // Forwarding of the write done in the previous cycle
    logic                  r_fwd_p_valid;
    logic [ADDR_W-1:0]     r_fwd_p_addr;
    logic [COUNT_BITS-1:0] r_fwd_p_data;
    logic                  r_fwd_t_valid;
    logic [3:0]            r_fwd_t_addr;
    logic [COUNT_BITS-1:0] r_fwd_t_data;

    // Output queue
    t_result               r_oq [OQ_DEPTH];
    logic [1:0]            r_oq_wr;
    logic [1:0]            r_oq_rd;
    logic [1:0]            r_oq_occ;

    // ------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------
    logic                  in_ready;
    logic                  in_accept;
    logic                  is_query;
    logic [2:0]            code;
    logic [4:0]            cls;
    logic [POS_W-1:0]      start_pos;
    logic                  pair_ok;
    logic [ADDR_W-1:0]     upd_addr;
    logic [ADDR_W-1:0]     qry_addr;
    logic                  qry_in_range;
    logic [ADDR_W-1:0]     p_raddr;
    logic [3:0]            t_raddr;

    logic [COUNT_BITS-1:0] p_rdata, t_rdata;
    logic [COUNT_BITS-1:0] p_cur, t_cur;
    logic [COUNT_BITS-1:0] p_inc, t_inc;
    logic                  p_we, t_we;
    logic [ADDR_W-1:0]     p_waddr;
    logic [3:0]            t_waddr;
    logic [COUNT_BITS-1:0] p_wdata, t_wdata;
    logic [63:0]           p_wide, t_wide;
    logic                  oq_push, oq_pop;
    t_result               res;
    logic [2:0]            oq_need;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    // Room for the beat in flight plus one more, from registered state only
    assign oq_need    = 3'(r_oq_occ) + 3'(r_s1_valid & r_s1_query);
    assign in_ready   = !r_clr_active && (oq_need < 3'(OQ_DEPTH));
    assign o_in_stall = !in_ready;
    assign in_accept  = i_in_valid && in_ready;
    assign is_query   = (i_mode == MODE_QUERY);

    // ------------------------------------------------------------------
    // Stage 0: classify the pair and form the RAM addresses
    // ------------------------------------------------------------------
    always_comb begin
        code      = base_code(i_base);
        start_pos = r_base_pos - POS_W'(1);
        if (r_prev_code == INVALID_CODE || code == INVALID_CODE) begin
            cls = NN_CLASS;
        end else begin
            cls = {1'b0, r_prev_code[1:0], code[1:0]};
        end
        pair_ok = (r_base_pos != '0) && (i_read_len == r_read_length) &&
                  (CMP_W'(r_base_pos) < CMP_W'(r_read_length));
        // start * 17 + class
        upd_addr = (ADDR_W'(start_pos) << 4) + ADDR_W'(start_pos) + ADDR_W'(cls);
        qry_addr = (ADDR_W'(i_query_position) << 4) + ADDR_W'(i_query_position)
                   + ADDR_W'(i_query_class);
        qry_in_range = (i_query_class <= NN_CLASS) &&
                       (32'(i_query_position) < 32'(MAX_READ_LEN));
        p_raddr = is_query ? qry_addr : upd_addr;
        t_raddr = is_query ? i_query_class[3:0] : cls[3:0];
    end

    // Advance position tracking on feed beats
    always_comb begin
        n_base_pos  = r_base_pos;
        n_prev_code = r_prev_code;
        if (in_accept && !is_query) begin
            if (i_last_base) begin
                n_base_pos  = '0;
                n_prev_code = INVALID_CODE;
            end else begin
                n_base_pos  = (r_base_pos == POS_LAST) ? '0 : r_base_pos + POS_W'(1);
                n_prev_code = code;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_length <= RLEN_RESET;
            r_base_pos    <= '0;
            r_prev_code   <= INVALID_CODE;
            r_clr_active  <= 1'b1;
            r_clr_addr    <= '0;
            r_s1_valid    <= 1'b0;
            r_fwd_p_valid <= 1'b0;
            r_fwd_t_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_read_length <= i_cfg_data;
            end
            r_base_pos  <= n_base_pos;
            r_prev_code <= n_prev_code;
            // Sweep the counter RAM to zero after reset
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == CLR_LAST) begin
                    r_clr_active <= 1'b0;
                end
            end
            r_s1_valid    <= in_accept;
            r_fwd_p_valid <= p_we && !r_clr_active;
            r_fwd_t_valid <= t_we && !r_clr_active;
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        r_s1_upd     <= !is_query && pair_ok;
        r_s1_tot_upd <= !is_query && pair_ok && (cls != NN_CLASS);
        r_s1_query   <= is_query;
        r_s1_qcnt    <= qry_in_range;
        r_s1_qtot    <= qry_in_range && (i_query_class != NN_CLASS);
        r_s1_paddr   <= p_raddr;
        r_s1_taddr   <= t_raddr;
        r_fwd_p_addr <= p_waddr;
        r_fwd_p_data <= p_wdata;
        r_fwd_t_addr <= t_waddr;
        r_fwd_t_data <= t_wdata;
    end

    // ------------------------------------------------------------------
    // Counter memories
    // ------------------------------------------------------------------
    pdh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    pdh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (16)
    ) u_total_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1: forward, saturating increment, write back, form result
    // ------------------------------------------------------------------
    always_comb begin
        p_cur = (r_fwd_p_valid && r_fwd_p_addr == r_s1_paddr) ? r_fwd_p_data : p_rdata;
        t_cur = (r_fwd_t_valid && r_fwd_t_addr == r_s1_taddr) ? r_fwd_t_data : t_rdata;
        p_inc = (p_cur == COUNT_MAX) ? p_cur : p_cur + COUNT_BITS'(1);
        t_inc = (t_cur == COUNT_MAX) ? t_cur : t_cur + COUNT_BITS'(1);

        // Clearing pass owns the write ports until it ends
        if (r_clr_active) begin
            p_we    = 1'b1;
            p_waddr = r_clr_addr;
            p_wdata = '0;
            t_we    = 1'b1;
            t_waddr = r_clr_addr[3:0];
            t_wdata = '0;
        end else begin
            p_we    = r_s1_valid && r_s1_upd;
            p_waddr = r_s1_paddr;
            p_wdata = p_inc;
            t_we    = r_s1_valid && r_s1_tot_upd;
            t_waddr = r_s1_taddr;
            t_wdata = t_inc;
        end

        p_wide = 64'(p_cur);
        t_wide = 64'(t_cur);
        res.position_count = r_s1_qcnt ? p_wide[OUT_W-1:0] : '0;
        res.class_total    = r_s1_qtot ? t_wide[OUT_W-1:0] : '0;
    end

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    assign oq_push = r_s1_valid && r_s1_query;
    assign oq_pop  = (r_oq_occ != 2'd0) && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr  <= '0;
            r_oq_rd  <= '0;
            r_oq_occ <= '0;
        end else begin
            if (oq_push) begin
                r_oq_wr <= (r_oq_wr == 2'(OQ_DEPTH - 1)) ? 2'd0 : r_oq_wr + 2'd1;
            end
            if (oq_pop) begin
                r_oq_rd <= (r_oq_rd == 2'(OQ_DEPTH - 1)) ? 2'd0 : r_oq_rd + 2'd1;
            end
            r_oq_occ <= r_oq_occ + 2'(oq_push) - 2'(oq_pop);
        end
    end

    // Hold result beats until taken
    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_oq_wr] <= res;
        end
    end

    assign o_out_valid      = (r_oq_occ != 2'd0);
    assign o_position_count = r_oq[r_oq_rd].position_count;
    assign o_class_total    = r_oq[r_oq_rd].class_total;

endmodule

`default_nettype wire

/* rtl/pdh_ram.sv */
// ============================================================================
// pdh_ram - generic simple dual-port RAM
// One write port, one read port, registered read data, read-before-write.
// ============================================================================
`default_nettype none

module pdh_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read; a same-address read returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* tb/positional_dinucleotide_histogram_unit_test.sv */
// ============================================================================
// positional_dinucleotide_histogram_unit_test - histogram unit testbench
// Streams reads and read-out beats into the unit and keeps its own model of
// the position/class counters and class totals. Every read-out result is
// checked against that model. The read length is changed between phases.
// ============================================================================
module positional_dinucleotide_histogram_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pdh_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int MAX_READ_LEN   = 256;
    localparam int SLOTS          = MAX_READ_LEN * NUM_CLASSES;
    localparam int SLOT_W         = $clog2(SLOTS);
    localparam int SETTLE_CYCLES  = 6;
    localparam int END_CYCLES     = 20;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic       mode;
        logic [7:0] base;
        logic [8:0] read_len;
        logic       last_base;
        logic [7:0] query_position;
        logic [4:0] query_class;
    } beat_t;

    // Clock, reset and DUT-facing signals
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [8:0] cfg_data  = '0;
    logic       in_valid  = 1'b0;
    logic       in_mode   = MODE_FEED;
    logic [7:0] in_base   = '0;
    logic [8:0] in_read_len = '0;
    logic       in_last   = 1'b0;
    logic [7:0] in_qpos   = '0;
    logic [4:0] in_qcls   = '0;
    logic       out_stall = 1'b0;
    logic       cfg_ready;
    logic       in_stall;
    logic       out_valid;
    logic [OUT_W-1:0] position_count;
    logic [OUT_W-1:0] class_total;

    // Histogram model state
    logic [31:0] pair_tally [SLOTS];
    logic [31:0] class_tally [16];
    int unsigned next_pos;
    logic [2:0]  prev_code;
    logic [8:0]  cur_read_length;

    // Read-out answers waiting for the output channel
    t_result pending_answers [$];

    // Traffic bookkeeping
    int    error_count  = 0;
    int    items_sent   = 0;
    int    burst_left   = 0;
    bit    gaps_off     = 1'b0;
    bit    hold_request = 1'b0;
    string base_letters = "ACGTacgt";

    always #(CLK_PERIOD / 2) clk = ~clk;

    positional_dinucleotide_histogram_unit dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_mode           (in_mode),
        .i_base           (in_base),
        .i_read_len       (in_read_len),
        .i_last_base      (in_last),
        .i_query_position (in_qpos),
        .i_query_class    (in_qcls),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_position_count (position_count),
        .o_class_total    (class_total)
    );

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------
    function automatic logic [2:0] nucleotide_code(input logic [7:0] ch);
        case (ch)
            "A", "a": return 3'd0;
            "C", "c": return 3'd1;
            "G", "g": return 3'd2;
            "T", "t": return 3'd3;
            default:  return INVALID_CODE;
        endcase
    endfunction

    task automatic clear_histogram();
        foreach (pair_tally[i]) pair_tally[i] = '0;
        foreach (class_tally[i]) class_tally[i] = '0;
        next_pos        = 0;
        prev_code       = INVALID_CODE;
        cur_read_length = RLEN_RESET;
    endtask

    // Apply one accepted beat to the model; read-outs queue their answer
    task automatic tally_beat(input beat_t b);
        t_result           ans;
        logic [2:0]        code;
        logic [4:0]        cls;
        logic [SLOT_W-1:0] slot;
        if (b.mode == MODE_QUERY) begin
            ans = '0;
            if (b.query_class <= NN_CLASS) begin
                slot = SLOT_W'(b.query_position * NUM_CLASSES + b.query_class);
                ans.position_count = pair_tally[slot];
                if (b.query_class < NN_CLASS)
                    ans.class_total = class_tally[b.query_class[3:0]];
            end
            pending_answers.push_back(ans);
        end else begin
            code = nucleotide_code(b.base);
            if (next_pos != 0 && b.read_len == cur_read_length && next_pos < cur_read_length) begin
                if (prev_code >= INVALID_CODE || code >= INVALID_CODE)
                    cls = NN_CLASS;
                else
                    cls = {1'b0, prev_code[1:0], code[1:0]};
                slot = SLOT_W'((next_pos - 1) * NUM_CLASSES + cls);
                // saturate instead of wrapping
                if (pair_tally[slot] != '1)
                    pair_tally[slot] = pair_tally[slot] + 1;
                if (cls < NN_CLASS && class_tally[cls[3:0]] != '1)
                    class_tally[cls[3:0]] = class_tally[cls[3:0]] + 1;
            end
            if (b.last_base) begin
                next_pos  = 0;
                prev_code = INVALID_CODE;
            end else begin
                next_pos  = (next_pos + 1) % MAX_READ_LEN;
                prev_code = code;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Beat generation and driving
    // ------------------------------------------------------------------------
    function automatic beat_t random_beat();
        beat_t b;
        b.mode           = 1'($urandom_range(0, 1));
        b.base           = 8'($urandom_range(0, 255));
        b.read_len       = 9'($urandom_range(0, 511));
        b.last_base      = 1'($urandom_range(0, 1));
        b.query_position = 8'($urandom_range(0, 255));
        b.query_class    = 5'($urandom_range(0, 31));
        return b;
    endfunction

    // Mostly real nucleotides in either case, some N, some arbitrary bytes
    function automatic logic [7:0] pick_base();
        int r;
        r = $urandom_range(0, 99);
        if (r < 84)
            return base_letters[$urandom_range(0, 7)];
        if (r < 90)
            return "N";
        return 8'($urandom_range(0, 255));
    endfunction

    // Start position likely to hold counts under the current read length
    function automatic logic [7:0] pick_position();
        int top;
        top = (cur_read_length > 256) ? 254 : int'(cur_read_length) - 2;
        if (top < 0)
            top = 0;
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, top));
    endfunction

    // Drive one beat from a falling edge, hold it until accepted
    task automatic send_beat(input beat_t b);
        int gap;
        if (!gaps_off && burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        in_valid    <= 1'b1;
        in_mode     <= b.mode;
        in_base     <= b.base;
        in_read_len <= b.read_len;
        in_last     <= b.last_base;
        in_qpos     <= b.query_position;
        in_qcls     <= b.query_class;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tally_beat(b);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_query(input logic [7:0] pos, input logic [4:0] cls);
        beat_t b;
        b = random_beat();
        b.mode           = MODE_QUERY;
        b.query_position = pos;
        b.query_class    = cls;
        send_beat(b);
    endtask

    task automatic feed_text(input string s, input logic [8:0] len_tag, input bit mark_end);
        beat_t b;
        for (int i = 0; i < s.len(); i++) begin
            b = random_beat();
            b.mode      = MODE_FEED;
            b.base      = s[i];
            b.read_len  = len_tag;
            b.last_base = mark_end && (i == s.len() - 1);
            send_beat(b);
        end
    endtask

    task automatic feed_read(input int len, input logic [8:0] len_tag, input bit mark_end);
        beat_t b;
        for (int i = 0; i < len; i++) begin
            b = random_beat();
            b.mode      = MODE_FEED;
            b.base      = pick_base();
            b.read_len  = len_tag;
            b.last_base = mark_end && (i == len - 1);
            send_beat(b);
        end
    endtask

    // Drop valid and wait until every answer is out and the pipe is empty
    task automatic wait_for_quiet();
        in_valid  <= 1'b0;
        burst_left = 0;
        while (pending_answers.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_read_length(input logic [8:0] len);
        wait_for_quiet();
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cur_read_length = len;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Counters read zero after the clearing pass, out-of-range class too
    task automatic test_cleared_after_reset();
        send_query(8'd0, 5'd0);
        send_query(8'd255, NN_CLASS);
        send_query(8'd128, 5'd31);
    endtask

    // Class mapping, case folding, NN, wrong length, bases past the length
    task automatic test_pair_classes();
        set_read_length(9'd4);
        feed_text("AcGt", 9'd4, 1'b1);
        feed_text("TNgA", 9'd4, 1'b1);
        feed_text("AAA", 9'd3, 1'b1);
        feed_text("CCCCC", 9'd4, 1'b1);
        send_query(8'd0, 5'd1);
        send_query(8'd1, 5'd6);
        send_query(8'd2, 5'd11);
        send_query(8'd0, NN_CLASS);
        send_query(8'd1, NN_CLASS);
        send_query(8'd2, 5'd8);
        send_query(8'd0, 5'd0);
        send_query(8'd2, 5'd5);
        send_query(8'd3, 5'd5);
        send_query(8'd0, 5'd31);
    endtask

    // Longest read length; one run of bases wraps the position counter
    task automatic test_position_wrap();
        beat_t b;
        set_read_length(9'd256);
        for (int i = 0; i < 300; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_query(pick_position(), 5'($urandom_range(0, 16)));
            end else begin
                b = random_beat();
                b.mode      = MODE_FEED;
                b.base      = pick_base();
                b.read_len  = 9'd256;
                b.last_base = (i == 299);
                send_beat(b);
            end
        end
        send_query(8'd0, 5'($urandom_range(0, 16)));
        send_query(8'd1, 5'($urandom_range(0, 16)));
        send_query(8'd254, 5'($urandom_range(0, 16)));
        send_query(8'd255, 5'($urandom_range(0, 16)));
    endtask

    // Receiver holds off long enough to back the unit up into its input
    task automatic test_backpressure();
        beat_t b;
        wait_for_quiet();
        hold_request = 1'b1;
        gaps_off     = 1'b1;
        for (int i = 0; i < 24; i++) begin
            if (i % 3 == 2) begin
                b = random_beat();
                b.mode = MODE_FEED;
                send_beat(b);
            end else begin
                send_query(pick_position(), 5'($urandom_range(0, 16)));
            end
        end
        gaps_off = 1'b0;
        wait_for_quiet();
    endtask

    // Mostly well-formed reads, plus wrong-length, broken and noise beats
    task automatic test_random_traffic(input int len, input int budget);
        int         stop;
        int         pick;
        logic [8:0] bad_len;
        set_read_length(len[8:0]);
        stop = items_sent + budget;
        while (items_sent < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                feed_read(len, len[8:0], 1'b1);
            end else if (pick < 60) begin
                bad_len = 9'($urandom_range(0, 511));
                if (bad_len == len[8:0])
                    bad_len = bad_len ^ 9'd1;
                feed_read($urandom_range(1, 8), bad_len, 1'b1);
            end else if (pick < 68) begin
                feed_read($urandom_range(1, len + 3), len[8:0], 1'($urandom_range(0, 1)));
            end else if (pick < 73) begin
                send_beat(random_beat());
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 9) == 0)
                        send_query(8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
                    else
                        send_query(pick_position(), 5'($urandom_range(0, 16)));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stall pattern, or one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : receiver
        int pattern_left;
        int stall_pct;
        pattern_left = 0;
        stall_pct    = 0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_request = 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    pattern_left = $urandom_range(8, 80);
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 25;
                        3:       stall_pct = 50;
                        default: stall_pct = 80;
                    endcase
                end
                pattern_left--;
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic flag_error(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, what);
    endtask

    always @(posedge clk) begin
        t_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_answers.size() == 0) begin
                flag_error($sformatf("unexpected result count=%0d total=%0d",
                                     position_count, class_total));
            end else begin
                want = pending_answers.pop_front();
                if (position_count !== want.position_count || class_total !== want.class_total)
                    flag_error($sformatf("count exp %0d got %0d, total exp %0d got %0d",
                                         want.position_count, position_count,
                                         want.class_total, class_total));
            end
        end
    end

    // Abort when no channel moves a beat for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        clear_histogram();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_cleared_after_reset();
        test_pair_classes();
        test_position_wrap();
        test_backpressure();
        test_random_traffic(2, 150);
        test_random_traffic($urandom_range(3, 16), 200);
        test_random_traffic($urandom_range(40, 100), 150);

        wait_for_quiet();
        repeat (END_CYCLES) @(negedge clk);
        if (error_count == 0 && pending_answers.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* positional_dinucleotide_histogram_unit.f */
rtl/pdh_pkg.sv
rtl/pdh_ram.sv
rtl/positional_dinucleotide_histogram_unit.sv
tb/positional_dinucleotide_histogram_unit_test.sv
